// ----- rtl/core/lqg_pkg.sv -----
`default_nettype none
package lqg_pkg;

    // default store sizes
    localparam int MAX_STATES_DEF       = 8;
    localparam int MAX_CONTROLS_DEF     = 4;
    localparam int MAX_MEASUREMENTS_DEF = 4;

    // word kinds
    localparam logic [2:0] KIND_LOAD = 3'd0;
    localparam logic [2:0] KIND_MEAS = 3'd1;
    localparam logic [2:0] KIND_CTRL = 3'd2;
    localparam logic [2:0] KIND_STEP = 3'd3;
    localparam logic [2:0] KIND_READ = 3'd4;

    // matrix selects
    localparam logic [2:0] SEL_A = 3'd0;
    localparam logic [2:0] SEL_B = 3'd1;
    localparam logic [2:0] SEL_C = 3'd2;
    localparam logic [2:0] SEL_K = 3'd3;
    localparam logic [2:0] SEL_L = 3'd4;

    // result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_SAT   = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;

    // multiplier coefficient source
    localparam logic [1:0] SRC_MEM = 2'd0;  // coefficient memory
    localparam logic [1:0] SRC_ONE = 2'd1;  // 1.0 in Q16.16
    localparam logic [1:0] SRC_DT  = 2'd2;  // time step register

    localparam logic signed [32:0] Q_ONE = 33'sd65536;

    // one term of a dot product, as it enters the MAC
    typedef struct packed {
        logic       valid;
        logic [1:0] src;
        logic       sub;
        logic       first;
        logic       last;
    } t_term_ctl;

    // coefficient memory layout: A, B, C, K, L back to back
    function automatic int coef_base(int sel, int ms, int mu, int mm);
        int b;
        b = 0;
        if (sel > 0) b = b + ms * ms;
        if (sel > 1) b = b + ms * mu;
        if (sel > 2) b = b + mm * ms;
        if (sel > 3) b = b + ms * mm;
        if (sel > 4) b = b + mu * ms;
        return b;
    endfunction

    // vector memory layout: x, u, z, e, dx back to back
    function automatic int vec_base(int sel, int ms, int mu, int mm);
        int b;
        b = 0;
        if (sel > 0) b = b + ms;
        if (sel > 1) b = b + mu;
        if (sel > 2) b = b + mm;
        if (sel > 3) b = b + mm;
        if (sel > 4) b = b + ms;
        return b;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lqg_mac.sv -----
`default_nettype none
// Shared MAC: registered multiply, saturating 64-bit accumulate,
// then >>16 with 32-bit saturation on the last term of each sum.
module lqg_mac #(
    parameter int VAW = 5
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  lqg_pkg::t_term_ctl      i_term,
    input  wire  [VAW-1:0]          i_waddr,
    input  wire  signed [31:0]      i_coef,
    input  wire  signed [31:0]      i_vec,
    input  wire  [30:0]             i_dt,
    input  wire                     i_clr_sat,
    output logic                    o_wr_en,
    output logic [VAW-1:0]          o_waddr,
    output logic signed [31:0]      o_wdata,
    output logic                    o_sat,
    output logic                    o_busy
);

    lqg_pkg::t_term_ctl r_s1, r_s2;
    logic [VAW-1:0]     r_s1_waddr, r_s2_waddr, r_s3_waddr;
    logic               r_s3_valid;
    logic signed [63:0] r_prod, r_acc;
    logic               r_sat;

    logic signed [32:0] a_op;
    logic signed [64:0] prod;
    logic signed [63:0] addend, base, sum, acc_next;
    logic               add_ovf, scale_ovf;

    // S1: pick coefficient, multiply
    always_comb begin
        case (r_s1.src)
            lqg_pkg::SRC_ONE: a_op = lqg_pkg::Q_ONE;
            lqg_pkg::SRC_DT:  a_op = $signed({2'b00, i_dt});
            default:          a_op = {i_coef[31], i_coef};
        endcase
        prod = a_op * i_vec;
    end

    // S2: saturating accumulate
    always_comb begin
        addend   = r_s2.sub ? -r_prod : r_prod;
        base     = r_s2.first ? 64'sd0 : r_acc;
        sum      = base + addend;
        add_ovf  = (base[63] == addend[63]) && (sum[63] != base[63]);
        acc_next = sum;
        if (add_ovf) acc_next = base[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end

    // S3: floor shift and clamp to 32 bits
    always_comb begin
        scale_ovf = !((&r_acc[63:47]) || !(|r_acc[63:47]));
        o_wdata   = r_acc[47:16];
        if (scale_ovf) o_wdata = r_acc[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        o_wr_en = r_s3_valid;
        o_waddr = r_s3_waddr;
        o_sat   = r_sat;
        o_busy  = r_s1.valid || r_s2.valid || r_s3_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1       <= '0;
            r_s2       <= '0;
            r_s3_valid <= 1'b0;
            r_sat      <= 1'b0;
        end else begin
            r_s1       <= i_term;
            r_s2       <= r_s1;
            r_s3_valid <= r_s2.valid && r_s2.last;
            if (i_clr_sat)
                r_sat <= 1'b0;
            else if ((r_s2.valid && add_ovf) || (r_s3_valid && scale_ovf))
                r_sat <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_waddr <= i_waddr;
        r_s2_waddr <= r_s1_waddr;
        r_s3_waddr <= r_s2_waddr;
        r_prod     <= prod[63:0];
        if (r_s2.valid) r_acc <= acc_next;
    end

endmodule
`default_nettype wire

// ----- rtl/core/lqg_seq.sv -----
`default_nettype none
// Term sequencer: walks phases innovation, dx, x update, control (when enabled),
// one term per cycle, draining the MAC between phases.
module lqg_seq #(
    parameter int MS   = 8,
    parameter int MU   = 4,
    parameter int MM   = 4,
    parameter int CNTW = 4,
    parameter int CAW  = 8,
    parameter int VAW  = 5
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire  [CNTW-1:0]     i_nx,
    input  wire  [CNTW-1:0]     i_nu,
    input  wire  [CNTW-1:0]     i_nz,
    input  wire                 i_ctrl_en,
    input  wire                 i_pipe_busy,
    output lqg_pkg::t_term_ctl  o_term,
    output logic [CAW-1:0]      o_coef_addr,
    output logic [VAW-1:0]      o_vec_addr,
    output logic [VAW-1:0]      o_waddr,
    output logic                o_done
);

    localparam int TW = $clog2(MS + MU + MM + 1);

    localparam logic [1:0] PH_INNOV = 2'd0;
    localparam logic [1:0] PH_DX    = 2'd1;
    localparam logic [1:0] PH_XUP   = 2'd2;
    localparam logic [1:0] PH_CTRL  = 2'd3;

    localparam int A_B = lqg_pkg::coef_base(0, MS, MU, MM);
    localparam int B_B = lqg_pkg::coef_base(1, MS, MU, MM);
    localparam int C_B = lqg_pkg::coef_base(2, MS, MU, MM);
    localparam int K_B = lqg_pkg::coef_base(3, MS, MU, MM);
    localparam int L_B = lqg_pkg::coef_base(4, MS, MU, MM);
    localparam int X_B = lqg_pkg::vec_base(0, MS, MU, MM);
    localparam int U_B = lqg_pkg::vec_base(1, MS, MU, MM);
    localparam int Z_B = lqg_pkg::vec_base(2, MS, MU, MM);
    localparam int E_B = lqg_pkg::vec_base(3, MS, MU, MM);
    localparam int D_B = lqg_pkg::vec_base(4, MS, MU, MM);

    logic            r_active, r_drain, r_done;
    logic [1:0]      r_phase;
    logic [CNTW-1:0] r_row;
    logic [TW-1:0]   r_term;

    logic [TW-1:0]   len;
    logic [CNTW-1:0] rows;
    logic            term_last, row_last;
    int              i, t, nx, nu;

    always_comb begin
        nx = int'(i_nx);
        nu = int'(i_nu);
        i  = int'(r_row);
        t  = int'(r_term);
        unique case (r_phase)
            PH_INNOV: begin
                len  = TW'(nx + 1);
                rows = i_nz;
            end
            PH_DX: begin
                len  = TW'(nx + nu + int'(i_nz));
                rows = i_nx;
            end
            PH_XUP: begin
                len  = TW'(2);
                rows = i_nx;
            end
            default: begin
                len  = TW'(nx);
                rows = i_nu;
            end
        endcase
        term_last = (r_term == len - TW'(1));
        row_last  = (r_row == rows - CNTW'(1));

        o_term       = '0;
        o_term.valid = r_active && !r_drain;
        o_term.first = (r_term == '0);
        o_term.last  = term_last;
        o_term.src   = lqg_pkg::SRC_MEM;
        o_coef_addr  = '0;
        o_vec_addr   = '0;
        o_waddr      = '0;
        unique case (r_phase)
            PH_INNOV: begin
                o_waddr = VAW'(E_B + i);
                if (t == 0) begin
                    o_term.src = lqg_pkg::SRC_ONE;
                    o_vec_addr = VAW'(Z_B + i);
                end else begin
                    o_term.sub  = 1'b1;
                    o_coef_addr = CAW'(C_B + i * MS + t - 1);
                    o_vec_addr  = VAW'(X_B + t - 1);
                end
            end
            PH_DX: begin
                o_waddr = VAW'(D_B + i);
                if (t < nx) begin
                    o_coef_addr = CAW'(A_B + i * MS + t);
                    o_vec_addr  = VAW'(X_B + t);
                end else if (t < nx + nu) begin
                    o_coef_addr = CAW'(B_B + i * MU + t - nx);
                    o_vec_addr  = VAW'(U_B + t - nx);
                end else begin
                    o_coef_addr = CAW'(K_B + i * MM + t - nx - nu);
                    o_vec_addr  = VAW'(E_B + t - nx - nu);
                end
            end
            PH_XUP: begin
                o_waddr = VAW'(X_B + i);
                if (t == 0) begin
                    o_term.src = lqg_pkg::SRC_ONE;
                    o_vec_addr = VAW'(X_B + i);
                end else begin
                    o_term.src = lqg_pkg::SRC_DT;
                    o_vec_addr = VAW'(D_B + i);
                end
            end
            default: begin
                o_waddr     = VAW'(U_B + i);
                o_term.sub  = 1'b1;
                o_coef_addr = CAW'(L_B + i * MS + t);
                o_vec_addr  = VAW'(X_B + t);
            end
        endcase
        o_done = r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_drain  <= 1'b0;
            r_done   <= 1'b0;
            r_phase  <= PH_INNOV;
            r_row    <= '0;
            r_term   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_drain  <= 1'b0;
                r_phase  <= PH_INNOV;
                r_row    <= '0;
                r_term   <= '0;
            end else if (r_active && !r_drain) begin
                if (term_last) begin
                    r_term <= '0;
                    if (row_last) begin
                        r_row   <= '0;
                        r_drain <= 1'b1;
                    end else begin
                        r_row <= r_row + CNTW'(1);
                    end
                end else begin
                    r_term <= r_term + TW'(1);
                end
            end else if (r_active && !i_pipe_busy) begin
                if (r_phase == PH_CTRL || (r_phase == PH_XUP && !i_ctrl_en)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end else begin
                    r_phase <= r_phase + 2'd1;
                    r_drain <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/lqg_observer_controller_step.sv -----
// Step word: the single MAC takes one term per cycle, pausing to drain after each
//   phase; then nu result words if control output is on, else one acknowledge
//   word, each sent once the output side is free.
// Load, write and read words: one result word each.
// The block takes no word while a word is in work; an output register holds a
//   finished result so the next word can be taken while it waits.
// Reset (synchronous, active low): registers to defaults, then a clearing pass over
//   the coefficient memory (192 words at defaults) zeroes all stores; o_ready low.
`default_nettype none
module lqg_observer_controller_step #(
    parameter int MAX_STATES       = lqg_pkg::MAX_STATES_DEF,
    parameter int MAX_CONTROLS     = lqg_pkg::MAX_CONTROLS_DEF,
    parameter int MAX_MEASUREMENTS = lqg_pkg::MAX_MEASUREMENTS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // input words
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  [2:0]         i_kind,
    input  wire  [2:0]         i_matrix_select,
    input  wire  [2:0]         i_row,
    input  wire  [2:0]         i_col,
    input  wire  signed [31:0] i_value,
    // result words
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [31:0] o_result_value,
    output logic [2:0]         o_result_index,
    output logic               o_last,
    output logic [1:0]         o_status,
    // register port
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [4:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int MS = MAX_STATES;
    localparam int MU = MAX_CONTROLS;
    localparam int MM = MAX_MEASUREMENTS;
    localparam int MAXN = (MS > MU) ? ((MS > MM) ? MS : MM) : ((MU > MM) ? MU : MM);
    localparam int CNTW = $clog2(MAXN + 1);

    localparam int CD  = lqg_pkg::coef_base(5, MS, MU, MM);  // coefficient depth
    localparam int VD  = lqg_pkg::vec_base(5, MS, MU, MM);   // vector depth
    localparam int CAW = $clog2(CD);
    localparam int VAW = $clog2(VD);

    localparam int A_B = lqg_pkg::coef_base(0, MS, MU, MM);
    localparam int B_B = lqg_pkg::coef_base(1, MS, MU, MM);
    localparam int C_B = lqg_pkg::coef_base(2, MS, MU, MM);
    localparam int K_B = lqg_pkg::coef_base(3, MS, MU, MM);
    localparam int L_B = lqg_pkg::coef_base(4, MS, MU, MM);
    localparam int X_B = lqg_pkg::vec_base(0, MS, MU, MM);
    localparam int U_B = lqg_pkg::vec_base(1, MS, MU, MM);
    localparam int Z_B = lqg_pkg::vec_base(2, MS, MU, MM);

    // word kinds
    localparam logic [2:0] KIND_LOAD = lqg_pkg::KIND_LOAD;
    localparam logic [2:0] KIND_MEAS = lqg_pkg::KIND_MEAS;
    localparam logic [2:0] KIND_CTRL = lqg_pkg::KIND_CTRL;
    localparam logic [2:0] KIND_STEP = lqg_pkg::KIND_STEP;
    localparam logic [2:0] KIND_READ = lqg_pkg::KIND_READ;
    // matrix selects
    localparam logic [2:0] SEL_A = lqg_pkg::SEL_A;
    localparam logic [2:0] SEL_B = lqg_pkg::SEL_B;
    localparam logic [2:0] SEL_C = lqg_pkg::SEL_C;
    localparam logic [2:0] SEL_K = lqg_pkg::SEL_K;
    localparam logic [2:0] SEL_L = lqg_pkg::SEL_L;
    // status codes
    localparam logic [1:0] STS_OK    = lqg_pkg::STS_OK;
    localparam logic [1:0] STS_SAT   = lqg_pkg::STS_SAT;
    localparam logic [1:0] STS_RANGE = lqg_pkg::STS_RANGE;
    // register indexes
    localparam logic [2:0] REG_NX = 3'd0;
    localparam logic [2:0] REG_NU = 3'd1;
    localparam logic [2:0] REG_NZ = 3'd2;
    localparam logic [2:0] REG_DT = 3'd3;
    localparam logic [2:0] REG_EN = 3'd4;
    // states
    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;  // vector read data arrives
    localparam logic [2:0] ST_PUSH = 3'd3;  // pending result to output reg
    localparam logic [2:0] ST_RUN  = 3'd4;  // step in the MAC
    localparam logic [2:0] ST_EMRD = 3'd5;  // issue read of u[k]

    // ---------------- configuration registers ----------------
    logic [3:0]  r_state_count;
    logic [2:0]  r_control_count, r_measurement_count;
    logic [30:0] r_time_step;
    logic        r_control_enable;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count       <= 4'd8;
            r_control_count     <= 3'd4;
            r_measurement_count <= 3'd4;
            r_time_step         <= 31'd655;
            r_control_enable    <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_NX:  r_state_count       <= pwdata[3:0];
                REG_NU:  r_control_count     <= pwdata[2:0];
                REG_NZ:  r_measurement_count <= pwdata[2:0];
                REG_DT:  r_time_step         <= pwdata[30:0];
                REG_EN:  r_control_enable    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_NX:  prdata = {28'd0, r_state_count};
            REG_NU:  prdata = {29'd0, r_control_count};
            REG_NZ:  prdata = {29'd0, r_measurement_count};
            REG_DT:  prdata = {1'b0, r_time_step};
            REG_EN:  prdata = {31'd0, r_control_enable};
            default: prdata = '0;
        endcase
    end

    // counts clamped to 1..max
    logic [CNTW-1:0] nx, nu, nz;
    always_comb begin
        if (r_state_count == '0)            nx = CNTW'(1);
        else if (int'(r_state_count) > MS)  nx = CNTW'(MS);
        else                                nx = CNTW'(r_state_count);
        if (r_control_count == '0)          nu = CNTW'(1);
        else if (int'(r_control_count) > MU) nu = CNTW'(MU);
        else                                nu = CNTW'(r_control_count);
        if (r_measurement_count == '0)      nz = CNTW'(1);
        else if (int'(r_measurement_count) > MM) nz = CNTW'(MM);
        else                                nz = CNTW'(r_measurement_count);
    end

    // ---------------- control ----------------
    logic [2:0]         r_state;
    logic [CAW-1:0]     r_clr_cnt;
    logic [CNTW-1:0]    r_k;
    logic               r_emit;
    logic signed [31:0] r_pv_value;
    logic [2:0]         r_pv_index;
    logic               r_pv_last;
    logic [1:0]         r_pv_status;
    logic               r_o_valid;
    logic signed [31:0] r_o_value;
    logic [2:0]         r_o_index;
    logic               r_o_last;
    logic [1:0]         r_o_status;

    logic accept, out_free;
    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;

    assign o_valid        = r_o_valid;
    assign o_result_value = r_o_value;
    assign o_result_index = r_o_index;
    assign o_last         = r_o_last;
    assign o_status       = r_o_status;

    // range checks and load address
    logic           row_x, row_u, row_z, col_x, col_u, col_z;
    logic           ld_ok, sel_ok;
    logic [CAW-1:0] ld_addr;
    int             ri, ci;
    always_comb begin
        ri    = int'(i_row);
        ci    = int'(i_col);
        row_x = ri < MS;
        row_u = ri < MU;
        row_z = ri < MM;
        col_x = ci < MS;
        col_u = ci < MU;
        col_z = ci < MM;
        sel_ok  = 1'b1;
        ld_ok   = 1'b0;
        ld_addr = '0;
        case (i_matrix_select)
            SEL_A: begin
                ld_ok   = row_x && col_x;
                ld_addr = CAW'(A_B + ri * MS + ci);
            end
            SEL_B: begin
                ld_ok   = row_x && col_u;
                ld_addr = CAW'(B_B + ri * MU + ci);
            end
            SEL_C: begin
                ld_ok   = row_z && col_x;
                ld_addr = CAW'(C_B + ri * MS + ci);
            end
            SEL_K: begin
                ld_ok   = row_x && col_z;
                ld_addr = CAW'(K_B + ri * MM + ci);
            end
            SEL_L: begin
                ld_ok   = row_u && col_x;
                ld_addr = CAW'(L_B + ri * MS + ci);
            end
            default: sel_ok = 1'b0;
        endcase
    end

    // ---------------- sequencer and MAC ----------------
    lqg_pkg::t_term_ctl seq_term;
    logic [CAW-1:0]     seq_coef_addr;
    logic [VAW-1:0]     seq_vec_addr, seq_waddr, mac_waddr;
    logic               seq_done, step_start;
    logic               mac_wr, mac_sat, mac_busy;
    logic signed [31:0] mac_wdata;
    logic signed [31:0] r_coef_q, r_vec_q;

    assign step_start = accept && (i_kind == KIND_STEP);

    lqg_seq #(
        .MS(MS), .MU(MU), .MM(MM), .CNTW(CNTW), .CAW(CAW), .VAW(VAW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (step_start),
        .i_nx        (nx),
        .i_nu        (nu),
        .i_nz        (nz),
        .i_ctrl_en   (r_control_enable),
        .i_pipe_busy (mac_busy),
        .o_term      (seq_term),
        .o_coef_addr (seq_coef_addr),
        .o_vec_addr  (seq_vec_addr),
        .o_waddr     (seq_waddr),
        .o_done      (seq_done)
    );

    lqg_mac #(.VAW(VAW)) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_term    (seq_term),
        .i_waddr   (seq_waddr),
        .i_coef    (r_coef_q),
        .i_vec     (r_vec_q),
        .i_dt      (r_time_step),
        .i_clr_sat (step_start),
        .o_wr_en   (mac_wr),
        .o_waddr   (mac_waddr),
        .o_wdata   (mac_wdata),
        .o_sat     (mac_sat),
        .o_busy    (mac_busy)
    );

    // ---------------- memories ----------------
    logic [31:0] r_coef_mem [CD];
    logic [31:0] r_vec_mem  [VD];

    logic           coef_we, vec_we;
    logic [CAW-1:0] coef_wa;
    logic [VAW-1:0] vec_wa, vec_ra;
    logic [31:0]    coef_wd, vec_wd;

    always_comb begin
        coef_we = 1'b0;
        coef_wa = ld_addr;
        coef_wd = i_value;
        vec_we  = 1'b0;
        vec_wa  = '0;
        vec_wd  = i_value;
        if (r_state == ST_CLR) begin
            coef_we = 1'b1;
            coef_wa = r_clr_cnt;
            coef_wd = '0;
            vec_we  = int'(r_clr_cnt) < VD;
            vec_wa  = VAW'(r_clr_cnt);
            vec_wd  = '0;
        end else if (mac_wr) begin
            vec_we = 1'b1;
            vec_wa = mac_waddr;
            vec_wd = mac_wdata;
        end else if (accept) begin
            coef_we = (i_kind == KIND_LOAD) && sel_ok && ld_ok;
            if (i_kind == KIND_MEAS && row_z) begin
                vec_we = 1'b1;
                vec_wa = VAW'(Z_B + ri);
            end
            if (i_kind == KIND_CTRL && row_u) begin
                vec_we = 1'b1;
                vec_wa = VAW'(U_B + ri);
            end
        end

        if (r_state == ST_RUN)       vec_ra = seq_vec_addr;
        else if (r_state == ST_EMRD) vec_ra = VAW'(U_B + int'(r_k));
        else if (row_x)              vec_ra = VAW'(X_B + ri);
        else                         vec_ra = '0;
    end

    always_ff @(posedge i_clk) begin
        if (coef_we) r_coef_mem[coef_wa] <= coef_wd;
        r_coef_q <= r_coef_mem[seq_coef_addr];
    end

    always_ff @(posedge i_clk) begin
        if (vec_we) r_vec_mem[vec_wa] <= vec_wd;
        r_vec_q <= r_vec_mem[vec_ra];
    end

    // ---------------- main FSM ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_clr_cnt <= '0;
            r_k       <= '0;
            r_emit    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // in ST_PUSH the push below owns the output valid
            if (r_o_valid && i_ready && r_state != ST_PUSH) r_o_valid <= 1'b0;
            unique case (r_state)
                ST_CLR: begin
                    r_clr_cnt <= r_clr_cnt + CAW'(1);
                    if (int'(r_clr_cnt) == CD - 1) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        case (i_kind)
                            KIND_STEP: r_state <= ST_RUN;
                            KIND_READ: r_state <= row_x ? ST_RD : ST_PUSH;
                            default:   r_state <= ST_PUSH;
                        endcase
                    end
                end
                ST_RD:   r_state <= ST_PUSH;
                ST_RUN: begin
                    if (seq_done) begin
                        if (r_control_enable) begin
                            r_emit  <= 1'b1;
                            r_k     <= '0;
                            r_state <= ST_EMRD;
                        end else begin
                            r_state <= ST_PUSH;
                        end
                    end
                end
                ST_EMRD: r_state <= ST_RD;
                ST_PUSH: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        if (r_emit && r_k != nu - CNTW'(1)) begin
                            r_k     <= r_k + CNTW'(1);
                            r_state <= ST_EMRD;
                        end else begin
                            r_emit  <= 1'b0;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_CLR;
            endcase
        end
    end

    // pending result and output register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pv_last <= 1'b1;
            case (i_kind)
                KIND_LOAD: begin
                    r_pv_value  <= sel_ok ? i_value : '0;
                    r_pv_index  <= sel_ok ? i_row : 3'd0;
                    r_pv_status <= (sel_ok && ld_ok) ? STS_OK : STS_RANGE;
                end
                KIND_MEAS: begin
                    r_pv_value  <= i_value;
                    r_pv_index  <= i_row;
                    r_pv_status <= row_z ? STS_OK : STS_RANGE;
                end
                KIND_CTRL: begin
                    r_pv_value  <= i_value;
                    r_pv_index  <= i_row;
                    r_pv_status <= row_u ? STS_OK : STS_RANGE;
                end
                KIND_READ: begin
                    r_pv_value  <= '0;
                    r_pv_index  <= i_row;
                    r_pv_status <= row_x ? STS_OK : STS_RANGE;
                end
                default: begin
                    r_pv_value  <= '0;
                    r_pv_index  <= 3'd0;
                    r_pv_status <= STS_RANGE;
                end
            endcase
        end else if (r_state == ST_RUN && seq_done) begin
            // acknowledge word when control output is off
            r_pv_value  <= '0;
            r_pv_index  <= 3'd0;
            r_pv_last   <= 1'b1;
            r_pv_status <= mac_sat ? STS_SAT : STS_OK;
        end else if (r_state == ST_EMRD) begin
            r_pv_index  <= 3'(r_k);
            r_pv_last   <= (r_k == nu - CNTW'(1));
            r_pv_status <= mac_sat ? STS_SAT : STS_OK;
        end else if (r_state == ST_RD) begin
            r_pv_value <= r_vec_q;
        end

        if (r_state == ST_PUSH && out_free) begin
            r_o_value  <= r_pv_value;
            r_o_index  <= r_pv_index;
            r_o_last   <= r_pv_last;
            r_o_status <= r_pv_status;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/lqg_checker.sv -----
`default_nettype none
module lqg_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_ready,
    input wire        o_valid,
    input wire        i_ready,
    input wire [31:0] o_result_value,
    input wire        o_last,
    input wire [1:0]  o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_value))
        else $error("result word dropped or changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("undefined status code");

    a_busy_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("new word taken before last result of a step");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("activity right after reset");

endmodule

bind lqg_observer_controller_step lqg_checker u_lqg_checker (.*);
`default_nettype wire
